@@ sv/top_clients_by_request_count_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the client ranking block
// Concurrent checks, clocked on clk and off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOP_CLIENTS_BY_REQUEST_COUNT_UNIT_DEFINES_SVH
`define TOP_CLIENTS_BY_REQUEST_COUNT_UNIT_DEFINES_SVH

// same-cycle implication
`define TCRC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcrc_pkg
// Types and codes shared by the client ranking block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrc_pkg;

	localparam int unsigned IP_W     = 32;
	localparam int unsigned PORT_W   = 16;
	localparam int unsigned TOTAL_W  = 32;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned FILL_W   = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_REFRESH = 2'd0,
		ACT_INSERT  = 2'd1,
		ACT_REPLACE = 2'd2,
		ACT_REJECT  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_BUBBLE,
		ST_PLACE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [IP_W-1:0]    ip;
		logic [PORT_W-1:0]  port;
		logic [TOTAL_W-1:0] total;
	} entry_t;

endpackage

`default_nettype wire

@@ sv/tcrc_ram.sv @@
// ----------------------------------------------------------------------------
// tcrc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrc_ram #(
	parameter int unsigned WIDTH = 80,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ sv/top_clients_by_request_count_unit.sv @@
// ----------------------------------------------------------------------------
// top_clients_by_request_count_unit
// Keeps the TOP_SIZE clients with the highest request totals, ranked.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall) carries one client per transfer: its
// address, port and current request total. Response channel
// (rsp_valid/rsp_stall) returns one result per request: action taken, whether
// the client is listed, its rank and the list fill count.
// The list lives in one entry RAM with a registered read. A request
// first scans the valid entries one per cycle, then walks the client upward,
// one RAM read and one shifted entry per cycle, and writes it at its rank.
// A client that is not admitted is neither walked nor written. The single read
// port of the entry RAM paces the scan and the walk.
// One request is in work at a time; req_stall is high until the result sits in
// the response register. A stalled response holds, and a new request is taken
// while it waits; its result then waits for the response register to drain.
// Reset empties the list (fill count zero); entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "top_clients_by_request_count_unit_defines.svh"

module top_clients_by_request_count_unit
	import tcrc_pkg::*;
#(
	parameter int unsigned TOP_SIZE = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [IP_W-1:0]     client_ip,
	input  wire logic [PORT_W-1:0]   client_port,
	input  wire logic [TOTAL_W-1:0]  request_total,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [ACTION_W-1:0]      action,
	output logic                     in_list,
	output logic [POS_W-1:0]         position,
	output logic [FILL_W-1:0]        fill_count
);

	localparam int unsigned IDX_W = (TOP_SIZE > 1) ? $clog2(TOP_SIZE) : 1;
	localparam int unsigned CNT_W = $clog2(TOP_SIZE + 1);
	localparam int unsigned PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam int unsigned FW    = (CNT_W > FILL_W) ? CNT_W : FILL_W;
	localparam int unsigned ENT_W = $bits(entry_t);

	state_t            state_q, state_d;
	entry_t            item_q, item_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	action_t           act_q, act_d;
	logic              inl_q, inl_d;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	entry_t            mem_wdata, rd_entry;
	logic [ENT_W-1:0]  mem_rdata;

	logic              rsp_valid_q;
	action_t           rsp_act_q;
	logic              rsp_inl_q;
	logic [PW-1:0]     rsp_pos_q;
	logic [FW-1:0]     rsp_fill_q;

	logic              req_xfer, rsp_xfer, rsp_free;
	logic              match, last_scan, full, admit_new, beats;
	logic [IDX_W-1:0]  start_idx, k_dec;

	tcrc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TOP_SIZE)
	) u_entry_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_entry  = entry_t'(mem_rdata);
	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_xfer  = rsp_valid_q && !rsp_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign match     = (rd_entry.ip == item_q.ip) && (rd_entry.port == item_q.port);
	assign last_scan = (CNT_W'(k_q) == (fill_q - CNT_W'(1)));
	assign full      = (fill_q == CNT_W'(TOP_SIZE));
	assign admit_new = !full || (item_q.total > rd_entry.total);
	assign beats     = (item_q.total > rd_entry.total);
	assign k_dec     = k_q - IDX_W'(1);
	assign start_idx = (match || full) ? k_q : IDX_W'(fill_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					state_d = (fill_q == '0) ? ST_PLACE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match || last_scan) begin
					if (!match && !admit_new) begin
						state_d = ST_DONE;
					end else if (start_idx == '0) begin
						state_d = ST_PLACE;
					end else begin
						state_d = ST_BUBBLE;
					end
				end
			end
			ST_BUBBLE: begin
				if (!beats) begin
					state_d = ST_DONE;
				end else if (k_dec == '0) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and RAM control
	always_comb begin
		item_d    = item_q;
		k_d       = k_q;
		fill_d    = fill_q;
		act_d     = act_q;
		inl_d     = inl_q;
		mem_we    = 1'b0;
		mem_waddr = k_q;
		mem_wdata = item_q;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					item_d.ip    = client_ip;
					item_d.port  = client_port;
					item_d.total = request_total;
					k_d          = '0;
					if (fill_q == '0) begin
						act_d  = ACT_INSERT;
						inl_d  = 1'b1;
						fill_d = fill_q + CNT_W'(1);
					end
				end
			end
			ST_SCAN: begin
				if (match || last_scan) begin
					k_d       = start_idx;
					mem_raddr = start_idx - IDX_W'(1);
					inl_d     = 1'b1;
					if (match) begin
						act_d = ACT_REFRESH;
					end else if (!full) begin
						act_d  = ACT_INSERT;
						fill_d = fill_q + CNT_W'(1);
					end else if (admit_new) begin
						act_d = ACT_REPLACE;
					end else begin
						act_d = ACT_REJECT;
						inl_d = 1'b0;
					end
				end else begin
					k_d       = k_q + IDX_W'(1);
					mem_raddr = k_q + IDX_W'(1);
				end
			end
			ST_BUBBLE: begin
				mem_we = 1'b1;
				if (beats) begin
					mem_wdata = rd_entry;
					k_d       = k_dec;
					mem_raddr = k_dec - IDX_W'(1);
				end
			end
			ST_PLACE: mem_we = 1'b1;
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		k_q    <= k_d;
		act_q  <= act_d;
		inl_q  <= inl_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_xfer) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_act_q  <= act_q;
			rsp_inl_q  <= inl_q;
			rsp_pos_q  <= inl_q ? PW'(k_q) : '0;
			rsp_fill_q <= FW'(fill_q);
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign action     = rsp_act_q;
	assign in_list    = rsp_inl_q;
	assign position   = rsp_pos_q[POS_W-1:0];
	assign fill_count = rsp_fill_q[FILL_W-1:0];

	`TCRC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CNT_W'(TOP_SIZE), "fill count above list size")
	`TCRC_ASSERT_IMPL(a_fill_step, fill_q != $past(fill_q), fill_q == $past(fill_q) + CNT_W'(1), "fill count moved by other than one")
	`TCRC_ASSERT_IMPL(a_no_idle_write, state_q == ST_IDLE || state_q == ST_DONE, !mem_we, "entry write outside of update")
	`TCRC_ASSERT_NEXT(a_xfer_busy, req_xfer, state_q != ST_IDLE, "request transfer did not start work")

endmodule

`default_nettype wire
